[design/abfc_pkg.sv]
// Shared types, codes and reset constants for the adaptive batch flush controller.
`timescale 1ns / 1ps
`default_nettype none

package abfc_pkg;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_PRESENT = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_RTT     = 2'd3
    } abfc_cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_INIT_CMD_LIMIT  = 3'd0,
        REG_INIT_BYTE_LIMIT = 3'd1,
        REG_FLUSH_ON_PRES   = 3'd2,
        REG_ADAPTIVE_MODE   = 3'd3,
        REG_MAX_INTERVAL    = 3'd4,
        REG_RTT_ALPHA       = 3'd5
    } abfc_reg_t;

    localparam int CMD_LIM_W  = 11;
    localparam int BYTE_LIM_W = 21;
    localparam int CNT_W      = 16;
    localparam int BYTES_W    = 24;
    localparam int TICKS_W    = 32;
    localparam int RTT_W      = 16;
    localparam int ALPHA_W    = 9;
    localparam int IVL_W      = 16;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CMD_LIM_W-1:0]  RST_CMD_LIMIT  = 11'd64;
    localparam logic [BYTE_LIM_W-1:0] RST_BYTE_LIMIT = 21'd65536;
    localparam logic                  RST_FLUSH_PRES = 1'b1;
    localparam logic                  RST_ADAPTIVE   = 1'b0;
    localparam logic [IVL_W-1:0]      RST_INTERVAL   = 16'd16;
    localparam logic [ALPHA_W-1:0]    RST_ALPHA      = 9'd32;
    localparam logic [ALPHA_W-1:0]    ALPHA_ONE      = 9'd256;

    // RTT thresholds for limit adaptation (ms)
    localparam logic [RTT_W-1:0] RTT_LOW  = 16'd5;
    localparam logic [RTT_W-1:0] RTT_HIGH = 16'd30;

    // Static configuration seen by the datapath
    typedef struct packed {
        logic               present_flush_en;
        logic               adaptive_mode;
        logic [IVL_W-1:0]   max_interval;
        logic [ALPHA_W-1:0] rtt_alpha;
    } abfc_cfg_t;

    // Live limit loads from a configuration write
    typedef struct packed {
        logic                  cmd_load;
        logic [CMD_LIM_W-1:0]  cmd_value;
        logic                  byte_load;
        logic [BYTE_LIM_W-1:0] byte_value;
    } abfc_lim_load_t;

    // One input request
    typedef struct packed {
        abfc_cmd_t      cmd;
        logic [15:0]    cmd_bytes;
        logic [RTT_W-1:0] rtt_ms;
    } abfc_item_t;

    // One result
    typedef struct packed {
        logic                  flushed;
        logic [CNT_W-1:0]      batch_count;
        logic [BYTES_W-1:0]    batch_bytes;
        logic [RTT_W-1:0]      avg_rtt;
        logic [CMD_LIM_W-1:0]  live_cmd_limit;
        logic [BYTE_LIM_W-1:0] live_byte_limit;
    } abfc_result_t;

    // Clamp to [lo, hi], upper bound applied last
    function automatic logic [31:0] clamp32(input logic [31:0] v,
                                            input logic [31:0] lo,
                                            input logic [31:0] hi);
        logic [31:0] t;
        begin
            t = (v < lo) ? lo : v;
            clamp32 = (t > hi) ? hi : t;
        end
    endfunction

endpackage

`default_nettype wire

[design/abfc_cfg.sv]
// Configuration register file and live limit load pulses.
`timescale 1ns / 1ps
`default_nettype none

module abfc_cfg
    import abfc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output abfc_cfg_t                  cfg,
    output abfc_lim_load_t             lim_load
);

    logic               fop_reg, fop_next;
    logic               adapt_reg, adapt_next;
    logic [IVL_W-1:0]   ivl_reg, ivl_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    abfc_reg_t          idx;

    assign idx = abfc_reg_t'(wr_index);

    // Register decode
    always_comb begin
        fop_next   = fop_reg;
        adapt_next = adapt_reg;
        ivl_next   = ivl_reg;
        alpha_next = alpha_reg;
        lim_load   = '0;
        lim_load.cmd_value  = wr_data[CMD_LIM_W-1:0];
        lim_load.byte_value = wr_data[BYTE_LIM_W-1:0];
        if (wr_en) begin
            case (idx)
                REG_INIT_CMD_LIMIT:  lim_load.cmd_load  = 1'b1;
                REG_INIT_BYTE_LIMIT: lim_load.byte_load = 1'b1;
                REG_FLUSH_ON_PRES:   fop_next   = wr_data[0];
                REG_ADAPTIVE_MODE:   adapt_next = wr_data[0];
                REG_MAX_INTERVAL:    ivl_next   = wr_data[IVL_W-1:0];
                REG_RTT_ALPHA:       alpha_next = wr_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fop_reg   <= RST_FLUSH_PRES;
            adapt_reg <= RST_ADAPTIVE;
            ivl_reg   <= RST_INTERVAL;
            alpha_reg <= RST_ALPHA;
        end else begin
            fop_reg   <= fop_next;
            adapt_reg <= adapt_next;
            ivl_reg   <= ivl_next;
            alpha_reg <= alpha_next;
        end
    end

    assign cfg.present_flush_en = fop_reg;
    assign cfg.adaptive_mode    = adapt_reg;
    assign cfg.max_interval     = ivl_reg;
    assign cfg.rtt_alpha        = alpha_reg;

endmodule

`default_nettype wire

[design/abfc_core.sv]
// Batch state registers and the single-pass update for one request.
`timescale 1ns / 1ps
`default_nettype none

module abfc_core
    import abfc_pkg::*;
#(
    parameter int MIN_CMD_LIMIT  = 8,
    parameter int MAX_CMD_LIMIT  = 1024,
    parameter int MIN_BYTE_LIMIT = 4096,
    parameter int MAX_BYTE_LIMIT = 1048576
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     commit,
    input  abfc_item_t    item,
    input  abfc_cfg_t     cfg,
    input  abfc_lim_load_t lim_load,
    output abfc_result_t  result
);

    localparam logic [31:0] MIN_C = 32'(MIN_CMD_LIMIT);
    localparam logic [31:0] MAX_C = 32'(MAX_CMD_LIMIT);
    localparam logic [31:0] MIN_B = 32'(MIN_BYTE_LIMIT);
    localparam logic [31:0] MAX_B = 32'(MAX_BYTE_LIMIT);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;
    logic [TICKS_W-1:0]    ticks_reg, ticks_next;
    logic [RTT_W-1:0]      rtt_reg, rtt_next;
    logic [CMD_LIM_W-1:0]  clim_reg, clim_next;
    logic [BYTE_LIM_W-1:0] blim_reg, blim_next;

    logic [CNT_W-1:0]      app_count;
    logic [BYTES_W:0]      byte_sum;
    logic [BYTES_W-1:0]    app_bytes;
    logic                  app_hit;
    logic                  do_flush;
    logic [CNT_W-1:0]      fl_count;
    logic [BYTES_W-1:0]    fl_bytes;
    logic [CMD_LIM_W-1:0]  clim_adapt;
    logic [BYTE_LIM_W-1:0] blim_adapt;
    logic [ALPHA_W-1:0]    alpha_eff;
    logic signed [RTT_W:0]       rtt_diff;
    logic signed [RTT_W+ALPHA_W+1:0] rtt_prod;
    logic signed [RTT_W+ALPHA_W+1:0] rtt_step;

    // Append totals, saturating
    assign app_count = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign byte_sum  = {1'b0, bytes_reg} + {{(BYTES_W-16+1){1'b0}}, item.cmd_bytes};
    assign app_bytes = byte_sum[BYTES_W] ? {BYTES_W{1'b1}} : byte_sum[BYTES_W-1:0];
    assign app_hit   = (app_count >= {{(CNT_W-CMD_LIM_W){1'b0}}, clim_reg})
                    || (app_bytes >= {{(BYTES_W-BYTE_LIM_W){1'b0}}, blim_reg})
                    || ((cfg.max_interval != '0)
                        && (ticks_reg >= {{(TICKS_W-IVL_W){1'b0}}, cfg.max_interval}));

    // Flush decision and batch totals
    always_comb begin
        do_flush = 1'b0;
        fl_count = count_reg;
        fl_bytes = bytes_reg;
        case (item.cmd)
            CMD_APPEND: begin
                do_flush = app_hit;
                fl_count = app_count;
                fl_bytes = app_bytes;
            end
            CMD_PRESENT: do_flush = cfg.present_flush_en && (count_reg != '0);
            default: ;
        endcase
    end

    // Limit adaptation from the smoothed RTT
    always_comb begin
        clim_adapt = clim_reg;
        blim_adapt = blim_reg;
        if (cfg.adaptive_mode) begin
            if (rtt_reg < RTT_LOW) begin
                clim_adapt = CMD_LIM_W'(clamp32(32'(clim_reg >> 1), MIN_C, MAX_C));
                blim_adapt = BYTE_LIM_W'(clamp32(32'(blim_reg >> 1), MIN_B, MAX_B));
            end else if (rtt_reg > RTT_HIGH) begin
                clim_adapt = CMD_LIM_W'(clamp32(
                    (32'({clim_reg, 1'b0}) > MAX_C) ? MAX_C : 32'({clim_reg, 1'b0}),
                    MIN_C, MAX_C));
                blim_adapt = BYTE_LIM_W'(clamp32(
                    (32'({blim_reg, 1'b0}) > MAX_B) ? MAX_B : 32'({blim_reg, 1'b0}),
                    MIN_B, MAX_B));
            end
        end
    end

    // RTT average: old + floor(a * (rtt - old) / 256)
    assign alpha_eff = (cfg.rtt_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.rtt_alpha;
    assign rtt_diff  = $signed({1'b0, item.rtt_ms}) - $signed({1'b0, rtt_reg});
    assign rtt_prod  = $signed({1'b0, alpha_eff}) * rtt_diff;
    assign rtt_step  = rtt_prod >>> 8;

    // Next state
    always_comb begin
        count_next = count_reg;
        bytes_next = bytes_reg;
        ticks_next = ticks_reg;
        rtt_next   = rtt_reg;
        clim_next  = clim_reg;
        blim_next  = blim_reg;
        if (commit) begin
            case (item.cmd)
                CMD_APPEND: begin
                    count_next = app_count;
                    bytes_next = app_bytes;
                end
                CMD_TICK: begin
                    if (ticks_reg != '1) begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                end
                CMD_RTT: rtt_next = rtt_reg + rtt_step[RTT_W-1:0];
                default: ;
            endcase
            if (do_flush) begin
                count_next = '0;
                bytes_next = '0;
                ticks_next = '0;
                clim_next  = clim_adapt;
                blim_next  = blim_adapt;
            end
        end
        if (lim_load.cmd_load) begin
            clim_next = lim_load.cmd_value;
        end
        if (lim_load.byte_load) begin
            blim_next = lim_load.byte_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bytes_reg <= '0;
            ticks_reg <= '0;
            rtt_reg   <= '0;
            clim_reg  <= RST_CMD_LIMIT;
            blim_reg  <= RST_BYTE_LIMIT;
        end else begin
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            ticks_reg <= ticks_next;
            rtt_reg   <= rtt_next;
            clim_reg  <= clim_next;
            blim_reg  <= blim_next;
        end
    end

    // Result for this request
    assign result.flushed         = do_flush;
    assign result.batch_count     = do_flush ? fl_count : '0;
    assign result.batch_bytes     = do_flush ? fl_bytes : '0;
    assign result.avg_rtt         = rtt_next;
    assign result.live_cmd_limit  = do_flush ? clim_adapt : clim_reg;
    assign result.live_byte_limit = do_flush ? blim_adapt : blim_reg;

endmodule

`default_nettype wire

[design/adaptive_batch_flush_controller.sv]
// Top level: input register, batch update core, result register and config port.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  s_tuser = cmd, s_tdata = cmd_bytes, rtt_ms
//  m_       out        m_tvalid/m_tready  m_tuser = flushed, m_tdata = batch fields
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  One request per cycle sustained while m_tready keeps the result register draining;
//  m_tvalid rises once a request has passed the input register and then the result
//  register. Throughput is set by the single-pass state update in the core.
//  aresetn is synchronous, active low; it clears state, config and both valid bits.
//  A stalled m_ side holds its result; s_tready stays high while the input register
//  can drain into the result register in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_batch_flush_controller
    import abfc_pkg::*;
#(
    parameter int MIN_CMD_LIMIT  = 8,
    parameter int MAX_CMD_LIMIT  = 1024,
    parameter int MIN_BYTE_LIMIT = 4096,
    parameter int MAX_BYTE_LIMIT = 1048576
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // [15:0] cmd_bytes, [31:16] rtt_ms
    input  wire logic [1:0]            s_tuser,   // [1:0] cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [87:0]                m_tdata,   // [15:0] batch_count, [39:16] batch_bytes,
                                                  // [55:40] avg_rtt, [66:56] live_cmd_limit,
                                                  // [87:67] live_byte_limit
    output logic [0:0]                 m_tuser,   // [0] flushed
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic           in_valid_reg, in_valid_next;
    abfc_item_t     item_reg;
    logic           out_valid_reg, out_valid_next;
    abfc_result_t   res_reg;
    logic           advance;
    abfc_result_t   result;
    abfc_cfg_t      cfg;
    abfc_lim_load_t lim_load;

    assign cfg_ready = 1'b1;

    abfc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .lim_load (lim_load)
    );

    abfc_core #(
        .MIN_CMD_LIMIT  (MIN_CMD_LIMIT),
        .MAX_CMD_LIMIT  (MAX_CMD_LIMIT),
        .MIN_BYTE_LIMIT (MIN_BYTE_LIMIT),
        .MAX_BYTE_LIMIT (MAX_BYTE_LIMIT)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .commit   (advance),
        .item     (item_reg),
        .cfg      (cfg),
        .lim_load (lim_load),
        .result   (result)
    );

    // Pipeline flow control
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd       <= abfc_cmd_t'(s_tuser);
            item_reg.cmd_bytes <= s_tdata[15:0];
            item_reg.rtt_ms    <= s_tdata[31:16];
        end
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.flushed;
    assign m_tdata  = {res_reg.live_byte_limit, res_reg.live_cmd_limit, res_reg.avg_rtt,
                       res_reg.batch_bytes, res_reg.batch_count};

endmodule

`default_nettype wire

[design/abfc_checker.sv]
// Port-level checks for the controller and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module abfc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // No flush means zero batch totals
    a_no_flush_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[39:0] == 40'd0))
        else $error("batch totals nonzero without flush");

    // A flush always carries at least one command
    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] != 16'd0))
        else $error("empty batch flushed");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind adaptive_batch_flush_controller abfc_checker u_abfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the adaptive batch flush controller stream interface.
`timescale 1ns / 1ps

module tb_top;
    import abfc_pkg::*;

    // Adaptation bounds, matching the block's default parameters
    localparam int unsigned MIN_CMD_LIMIT  = 8;
    localparam int unsigned MAX_CMD_LIMIT  = 1024;
    localparam int unsigned MIN_BYTE_LIMIT = 4096;
    localparam int unsigned MAX_BYTE_LIMIT = 1048576;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;  // decodes to nothing
    localparam int LONG_STALL  = 400;
    localparam int TAIL_CYCLES = 6;
    localparam int PHASES      = 8;
    localparam int PHASE_HALF  = 100;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE
    } rx_pace_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [87:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    adaptive_batch_flush_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be offered, and results the block still owes
    abfc_item_t   pending_reqs[$];
    abfc_result_t due_results[$];

    // Mirror of the block's configuration and batch state
    logic [CMD_LIM_W-1:0]  mir_init_cmd  = RST_CMD_LIMIT;
    logic [BYTE_LIM_W-1:0] mir_init_byte = RST_BYTE_LIMIT;
    logic                  mir_on_pres   = RST_FLUSH_PRES;
    logic                  mir_adaptive  = RST_ADAPTIVE;
    logic [IVL_W-1:0]      mir_interval  = RST_INTERVAL;
    logic [ALPHA_W-1:0]    mir_alpha     = RST_ALPHA;
    logic [CNT_W-1:0]      mir_count     = '0;
    logic [BYTES_W-1:0]    mir_bytes     = '0;
    logic [TICKS_W-1:0]    mir_ticks     = '0;
    logic [RTT_W-1:0]      mir_rtt       = '0;
    logic [CMD_LIM_W-1:0]  mir_cmd_lim   = RST_CMD_LIMIT;
    logic [BYTE_LIM_W-1:0] mir_byte_lim  = RST_BYTE_LIMIT;

    int err_cnt     = 0;
    int req_cnt     = 0;
    int result_cnt  = 0;
    int flush_cnt   = 0;
    int cfg_cnt     = 0;
    int long_stall_reqs = 0;

    logic        in_fire = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int          stall_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_left = 0;
    rx_pace_t    rx_mode = RX_OPEN;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned fit_range(int unsigned v, int unsigned lo, int unsigned hi);
        int unsigned t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    // Advance the mirrored batch state by one request and form its result
    task automatic next_flush_result(input abfc_item_t req, output abfc_result_t res);
        logic [24:0] byte_sum;
        logic [31:0] mix;
        logic [8:0]  weight;
        logic        want_flush;
        res = '0;
        want_flush = 1'b0;
        case (req.cmd)
            CMD_APPEND: begin
                byte_sum = {1'b0, mir_bytes} + {9'd0, req.cmd_bytes};
                mir_bytes = byte_sum[24] ? '1 : byte_sum[23:0];
                if (mir_count != '1) mir_count = mir_count + 1'b1;
                want_flush = (32'(mir_count) >= 32'(mir_cmd_lim)) ||
                             (32'(mir_bytes) >= 32'(mir_byte_lim)) ||
                             (mir_interval != '0 && mir_count != '0 &&
                              mir_ticks >= 32'(mir_interval));
            end
            CMD_PRESENT: want_flush = mir_on_pres;
            CMD_TICK: begin
                if (mir_ticks != '1) mir_ticks = mir_ticks + 1'b1;
            end
            default: begin
                // alpha past one is treated as one: the sample replaces the average
                weight = (mir_alpha > ALPHA_ONE) ? ALPHA_ONE : mir_alpha;
                mix = 32'(weight) * 32'(req.rtt_ms) + (32'd256 - 32'(weight)) * 32'(mir_rtt);
                mir_rtt = mix[23:8];
            end
        endcase
        // An empty batch never flushes
        if (want_flush && mir_count != '0) begin
            res.flushed = 1'b1;
            res.batch_count = mir_count;
            res.batch_bytes = mir_bytes;
            mir_count = '0;
            mir_bytes = '0;
            mir_ticks = '0;
            if (mir_adaptive) begin
                if (mir_rtt < RTT_LOW) begin
                    mir_cmd_lim  = CMD_LIM_W'(fit_range(32'(mir_cmd_lim) >> 1,
                                                        MIN_CMD_LIMIT, MAX_CMD_LIMIT));
                    mir_byte_lim = BYTE_LIM_W'(fit_range(32'(mir_byte_lim) >> 1,
                                                         MIN_BYTE_LIMIT, MAX_BYTE_LIMIT));
                end else if (mir_rtt > RTT_HIGH) begin
                    mir_cmd_lim  = CMD_LIM_W'(fit_range(32'(mir_cmd_lim) << 1,
                                                        MIN_CMD_LIMIT, MAX_CMD_LIMIT));
                    mir_byte_lim = BYTE_LIM_W'(fit_range(32'(mir_byte_lim) << 1,
                                                         MIN_BYTE_LIMIT, MAX_BYTE_LIMIT));
                end
            end
        end
        res.avg_rtt = mir_rtt;
        res.live_cmd_limit = mir_cmd_lim;
        res.live_byte_limit = mir_byte_lim;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         result_cnt, name, want, got);
        end
    endtask

    // Register write; only issued while no request is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_INIT_CMD_LIMIT: begin
                mir_init_cmd = val[CMD_LIM_W-1:0];
                mir_cmd_lim  = val[CMD_LIM_W-1:0];
            end
            REG_INIT_BYTE_LIMIT: begin
                mir_init_byte = val[BYTE_LIM_W-1:0];
                mir_byte_lim  = val[BYTE_LIM_W-1:0];
            end
            REG_FLUSH_ON_PRES: mir_on_pres  = val[0];
            REG_ADAPTIVE_MODE: mir_adaptive = val[0];
            REG_MAX_INTERVAL:  mir_interval = val[IVL_W-1:0];
            REG_RTT_ALPHA:     mir_alpha    = val[ALPHA_W-1:0];
            default: ;
        endcase
        cfg_cnt++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_req(input abfc_cmd_t kind, input logic [15:0] nbytes,
                           input logic [RTT_W-1:0] rtt);
        abfc_item_t req;
        req.cmd = kind;
        req.cmd_bytes = nbytes;
        req.rtt_ms = rtt;
        pending_reqs.push_back(req);
    endtask

    // Random request mix: mostly appends and ticks so batches fill and time out
    task automatic queue_random(input int n);
        int          roll;
        abfc_cmd_t   kind;
        logic [15:0] nbytes;
        logic [15:0] rtt;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)      kind = CMD_APPEND;
            else if (roll < 75) kind = CMD_TICK;
            else if (roll < 85) kind = CMD_PRESENT;
            else                kind = CMD_RTT;
            case ($urandom_range(0, 9))
                0:             nbytes = '0;
                1:             nbytes = '1;
                2, 3, 4, 5:    nbytes = 16'($urandom_range(0, 2000));
                default:       nbytes = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3:    rtt = 16'($urandom_range(0, 40));
                4:             rtt = '0;
                5:             rtt = '1;
                default:       rtt = 16'($urandom);
            endcase
            add_req(kind, nbytes, rtt);
        end
    endtask

    // Wait until every offered request has its result, then a short tail
    task automatic settle();
        while (pending_reqs.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Request driver: bursts of random length separated by random gaps
    always @(negedge aclk) begin
        abfc_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= {nxt.rtt_ms, nxt.cmd_bytes};
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 32);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: long hold on request, otherwise a changing stall pattern
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_seen != long_stall_reqs) begin
            stall_seen = long_stall_reqs;
            hold_left = LONG_STALL;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_pace_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 128);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= !m_tready;
            endcase
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        abfc_item_t   req;
        abfc_result_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                req.cmd = abfc_cmd_t'(s_tuser);
                req.cmd_bytes = s_tdata[15:0];
                req.rtt_ms = s_tdata[31:16];
                next_flush_result(req, want);
                due_results.push_back(want);
                req_cnt++;
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected result: flushed %0d, data %h", m_tuser[0], m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("flushed", 32'(want.flushed), 32'(m_tuser[0]));
                    check_field("batch_count", 32'(want.batch_count), 32'(m_tdata[15:0]));
                    check_field("batch_bytes", 32'(want.batch_bytes), 32'(m_tdata[39:16]));
                    check_field("avg_rtt", 32'(want.avg_rtt), 32'(m_tdata[55:40]));
                    check_field("live_cmd_limit", 32'(want.live_cmd_limit),
                                32'(m_tdata[66:56]));
                    check_field("live_byte_limit", 32'(want.live_byte_limit),
                                32'(m_tdata[87:67]));
                    if (want.flushed) flush_cnt++;
                end
                result_cnt++;
            end
        end
    end

    // Stimulus sequence
    initial begin
        logic [CFG_DATA_W-1:0] val;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset settings: empty present, zero-byte append, byte limit, RTT extremes
        add_req(CMD_PRESENT, 16'd0, 16'd0);
        add_req(CMD_APPEND, 16'd0, 16'hFFFF);
        add_req(CMD_APPEND, 16'hFFFF, 16'd0);
        add_req(CMD_APPEND, 16'hFFFF, 16'd7);
        add_req(CMD_RTT, 16'hFFFF, 16'hFFFF);
        add_req(CMD_RTT, 16'h1234, 16'd0);
        add_req(CMD_APPEND, 16'd1, 16'h5555);
        add_req(CMD_PRESENT, 16'hAAAA, 16'hAAAA);
        add_req(CMD_TICK, 16'hFFFF, 16'hFFFF);
        settle();

        // Zero command limit, present flush off, alpha past one, short timeout
        write_reg(REG_INIT_CMD_LIMIT, 21'd0);
        write_reg(REG_INIT_BYTE_LIMIT, 21'h1FFFFF);
        write_reg(REG_FLUSH_ON_PRES, 21'h1FFFFE);
        write_reg(REG_ADAPTIVE_MODE, 21'd1);
        write_reg(REG_MAX_INTERVAL, 21'd3);
        write_reg(REG_RTT_ALPHA, 21'd511);
        add_req(CMD_APPEND, 16'd100, 16'd0);
        add_req(CMD_RTT, 16'd0, 16'd2);
        add_req(CMD_APPEND, 16'd5, 16'd0);
        add_req(CMD_PRESENT, 16'd0, 16'd0);
        add_req(CMD_TICK, 16'd0, 16'd0);
        add_req(CMD_TICK, 16'd0, 16'd0);
        add_req(CMD_TICK, 16'd0, 16'd0);
        add_req(CMD_APPEND, 16'd9, 16'd0);
        add_req(CMD_RTT, 16'd0, 16'd30);
        add_req(CMD_APPEND, 16'd3, 16'd0);
        add_req(CMD_RTT, 16'd0, 16'd31);
        add_req(CMD_PRESENT, 16'd0, 16'd0);
        settle();

        // Oversized command limit, zero byte limit, widest timeout, spare index
        write_reg(REG_INIT_CMD_LIMIT, 21'h7FF);
        write_reg(REG_INIT_BYTE_LIMIT, 21'd0);
        write_reg(REG_FLUSH_ON_PRES, 21'd1);
        write_reg(REG_MAX_INTERVAL, 21'hFFFF);
        write_reg(REG_RTT_ALPHA, 21'd256);
        write_reg(REG_SPARE, 21'h1FFFFF);
        add_req(CMD_APPEND, 16'd7, 16'd0);
        add_req(CMD_RTT, 16'd0, 16'd4);
        add_req(CMD_APPEND, 16'd0, 16'd0);
        add_req(CMD_PRESENT, 16'd0, 16'd0);
        settle();

        // Random phases: flag, timeout and alpha settings rewritten each phase, limits in some
        for (int p = 0; p < PHASES; p++) begin
            if ($urandom_range(0, 1) || p == 0) begin
                case ($urandom_range(0, 9))
                    0, 1:    val = 21'($urandom_range(1, 16));
                    2, 3:    val = 21'($urandom_range(1, 200));
                    4:       val = 21'd0;
                    5:       val = 21'h7FF;
                    6:       val = 21'd1024;
                    default: val = 21'($urandom_range(0, 2047));
                endcase
                write_reg(REG_INIT_CMD_LIMIT, val);
                case ($urandom_range(0, 9))
                    0, 1, 2: val = 21'($urandom_range(1, 50000));
                    3, 4:    val = 21'($urandom_range(4096, 300000));
                    5:       val = 21'd0;
                    6:       val = 21'h1FFFFF;
                    7:       val = 21'd1048576;
                    default: val = 21'($urandom);
                endcase
                write_reg(REG_INIT_BYTE_LIMIT, val);
            end
            val = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 1));
            write_reg(REG_FLUSH_ON_PRES, val);
            val = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 2) != 0);
            write_reg(REG_ADAPTIVE_MODE, val);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: val = 21'($urandom_range(0, 20));
                4, 5:       val = 21'd0;
                6:          val = 21'hFFFF;
                default:    val = 21'($urandom_range(0, 65535));
            endcase
            write_reg(REG_MAX_INTERVAL, val);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: val = 21'($urandom_range(0, 64));
                4:          val = 21'd0;
                5:          val = 21'd256;
                6:          val = 21'd511;
                default:    val = 21'($urandom_range(0, 511));
            endcase
            write_reg(REG_RTT_ALPHA, val);

            queue_random(PHASE_HALF);
            // Hold the receiver off while the sender keeps offering
            if (p == 1 || p == 5) long_stall_reqs++;
            // Sender pauses until every result is back, then resumes
            settle();
            queue_random(PHASE_HALF);
            settle();
        end

        $display("Checked %0d results for %0d requests, %0d of them flushes,",
                 result_cnt, req_cnt, flush_cnt);
        $display("across %0d register writes with receiver holds and sender gaps.", cfg_cnt);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("timeout: %0d results still due", due_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
